// ===== rtl/pfcs_pkg.sv =====
// types and constants shared by the particle fade/color/size pipeline
// no dependencies
package pfcs_pkg;

    localparam int DIV_STEPS = 16;
    localparam int LATENCY   = 23;

    localparam logic [16:0] RATIO_ONE   = 17'h10000;
    localparam logic [19:0] RADIUS_BASE = 20'd458752;
    localparam logic [12:0] RECIP_10    = 13'd6554;
    localparam logic [14:0] RECIP_75    = 15'd27963;
    localparam logic [11:0] HUE_LIFE_K  = 12'd3600;

    localparam logic signed [30:0] HUE_FULL   = 31'sd235929600;
    localparam logic signed [30:0] HUE_FULL_2 = 31'sd471859200;
    localparam logic [27:0] HUE_SECTOR = 28'd39321600;

    localparam logic [2:0] SEC_0 = 3'd0;
    localparam logic [2:0] SEC_1 = 3'd1;
    localparam logic [2:0] SEC_2 = 3'd2;
    localparam logic [2:0] SEC_3 = 3'd3;
    localparam logic [2:0] SEC_4 = 3'd4;
    localparam logic [2:0] SEC_5 = 3'd5;

    typedef struct packed {
        logic               sat;
        logic               mode;
        logic signed [16:0] pos_sum;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [11:0]        size;
    } side_t;

endpackage

// ===== rtl/particle_fade_color_size.sv =====
// particle draw attributes: faded alpha, shrinking radius, center, hue color
// depends on pfcs_pkg and pfcs_div
//
// usage
//   a particle word is taken at each clock edge where start is high and busy
//   is low; busy is always low, so one word can enter every cycle
//   a live particle gives one result word, marked by done for one cycle;
//   a word with is_live low gives no result
//   throughput is one word per cycle; the pipeline is an input stage, the
//   16-stage ratio divider (one quotient bit per stage) and six stages of
//   multiply, hue wrap, sector and reciprocal scaling
//   rainbow_mode is written through cfg_we/cfg_data while nothing is in flight
//   and is sampled with each word as it enters
//   reset clears all valid bits and sets rainbow_mode to 0; words in flight
//   are dropped
//   the receiver cannot stall: done words must be taken in their cycle
module particle_fade_color_size
    import pfcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_we,
    input  logic               cfg_data,
    input  logic               is_live,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [15:0]        life_left,
    input  logic [15:0]        life_total,
    input  logic [7:0]         base_red,
    input  logic [7:0]         base_green,
    input  logic [7:0]         base_blue,
    input  logic [7:0]         base_alpha,
    input  logic [11:0]        dot_size,
    output logic               done,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic [7:0]         out_alpha,
    output logic signed [11:0] center_x,
    output logic signed [11:0] center_y,
    output logic [7:0]         dot_radius
);

    logic mode_reg;

    side_t              in_side;
    logic               in_valid;
    logic signed [11:0] cx_in;
    logic signed [11:0] cy_in;

    logic        div_valid;
    logic [15:0] div_quot;
    side_t       div_side;

    assign busy     = 1'b0;
    assign in_valid = start & is_live;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    // truncate toward zero
    always_comb
    begin
        cx_in = pos_x[15:4];
        cy_in = pos_y[15:4];
        if (pos_x[15] && (pos_x[3:0] != 4'd0))
        begin
            cx_in = cx_in + 12'sd1;
        end
        if (pos_y[15] && (pos_y[3:0] != 4'd0))
        begin
            cy_in = cy_in + 12'sd1;
        end
        in_side.sat     = (life_total == 16'd0) || (life_left >= life_total);
        in_side.mode    = mode_reg;
        in_side.pos_sum = 17'(pos_x) + 17'(pos_y);
        in_side.cx      = cx_in;
        in_side.cy      = cy_in;
        in_side.red     = base_red;
        in_side.green   = base_green;
        in_side.blue    = base_blue;
        in_side.alpha   = base_alpha;
        in_side.size    = dot_size;
    end

    pfcs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_left   (life_left),
        .in_total  (life_total),
        .in_side   (in_side),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // e1: ratio, products, raw hue
    logic               v1_reg;
    logic               mode1_reg;
    logic [23:0]        rgb1_reg;
    logic [24:0]        aprod1_reg;
    logic [31:0]        sprod1_reg;
    logic signed [30:0] hraw1_reg;
    logic signed [11:0] cx1_reg;
    logic signed [11:0] cy1_reg;

    logic [16:0]        ratio;
    logic [19:0]        scale;
    logic [27:0]        hue_life;
    logic signed [30:0] hue_pos;
    logic [24:0]        aprod1_next;
    logic [31:0]        sprod1_next;
    logic signed [30:0] hraw1_next;

    always_comb
    begin
        ratio       = div_side.sat ? RATIO_ONE : {1'b0, div_quot};
        scale       = RADIUS_BASE + 20'(ratio) * 20'd3;
        hue_life    = 28'(ratio) * 28'(HUE_LIFE_K);
        hue_pos     = {{2{div_side.pos_sum[16]}}, div_side.pos_sum, 12'b0};
        aprod1_next = 25'(div_side.alpha) * 25'(ratio);
        sprod1_next = 32'(div_side.size) * 32'(scale);
        hraw1_next  = $signed({3'b0, hue_life}) + hue_pos;
    end

    // e2: alpha, radius numerator, hue wrap
    logic               v2_reg;
    logic               mode2_reg;
    logic [23:0]        rgb2_reg;
    logic [7:0]         alpha2_reg;
    logic [11:0]        rv2_reg;
    logic [27:0]        hue2_reg;
    logic signed [11:0] cx2_reg;
    logic signed [11:0] cy2_reg;

    logic signed [30:0] hwrap;

    always_comb
    begin
        if (hraw1_reg < 0)
        begin
            hwrap = (hraw1_reg + HUE_FULL >= 0) ? hraw1_reg + HUE_FULL
                                                 : hraw1_reg + HUE_FULL_2;
        end
        else if (hraw1_reg >= HUE_FULL_2)
        begin
            hwrap = hraw1_reg - HUE_FULL_2;
        end
        else if (hraw1_reg >= HUE_FULL)
        begin
            hwrap = hraw1_reg - HUE_FULL;
        end
        else
        begin
            hwrap = hraw1_reg;
        end
    end

    // e3: radius reciprocal product, sector split
    logic               v3_reg;
    logic               mode3_reg;
    logic [23:0]        rgb3_reg;
    logic [7:0]         alpha3_reg;
    logic [24:0]        rprod3_reg;
    logic [2:0]         sec3_reg;
    logic [25:0]        frac3_reg;
    logic signed [11:0] cx3_reg;
    logic signed [11:0] cy3_reg;

    logic [2:0]  sec_next;
    logic [27:0] frac_full;

    always_comb
    begin
        if (hue2_reg >= 28'd5 * HUE_SECTOR)
        begin
            sec_next = SEC_5;
        end
        else if (hue2_reg >= 28'd4 * HUE_SECTOR)
        begin
            sec_next = SEC_4;
        end
        else if (hue2_reg >= 28'd3 * HUE_SECTOR)
        begin
            sec_next = SEC_3;
        end
        else if (hue2_reg >= 28'd2 * HUE_SECTOR)
        begin
            sec_next = SEC_2;
        end
        else if (hue2_reg >= HUE_SECTOR)
        begin
            sec_next = SEC_1;
        end
        else
        begin
            sec_next = SEC_0;
        end
        frac_full = hue2_reg - 28'(sec_next) * HUE_SECTOR;
    end

    // e4: radius, scaled offset
    logic               v4_reg;
    logic               mode4_reg;
    logic [23:0]        rgb4_reg;
    logic [7:0]         alpha4_reg;
    logic [7:0]         rad4_reg;
    logic [2:0]         sec4_reg;
    logic [14:0]        xnum4_reg;
    logic signed [11:0] cx4_reg;
    logic signed [11:0] cy4_reg;

    logic [25:0] gsel;
    logic [33:0] g255;

    always_comb
    begin
        gsel = sec3_reg[0] ? HUE_SECTOR[25:0] - frac3_reg : frac3_reg;
        g255 = {gsel, 8'b0} - 34'(gsel);
    end

    // e5: divide by 75 via reciprocal
    logic               v5_reg;
    logic               mode5_reg;
    logic [23:0]        rgb5_reg;
    logic [7:0]         alpha5_reg;
    logic [7:0]         rad5_reg;
    logic [2:0]         sec5_reg;
    logic [29:0]        xprod5_reg;
    logic signed [11:0] cx5_reg;
    logic signed [11:0] cy5_reg;

    // e6: output word
    logic               done_reg;
    logic [7:0]         red_reg;
    logic [7:0]         green_reg;
    logic [7:0]         blue_reg;
    logic [7:0]         alpha_reg;
    logic [7:0]         rad_reg;
    logic signed [11:0] cx_reg;
    logic signed [11:0] cy_reg;

    logic [7:0] xval;
    logic [7:0] red_next;
    logic [7:0] green_next;
    logic [7:0] blue_next;

    always_comb
    begin
        xval = xprod5_reg[28:21];
        case (sec5_reg)
            SEC_0:
            begin
                red_next = 8'd255; green_next = xval;   blue_next = 8'd0;
            end
            SEC_1:
            begin
                red_next = xval;   green_next = 8'd255; blue_next = 8'd0;
            end
            SEC_2:
            begin
                red_next = 8'd0;   green_next = 8'd255; blue_next = xval;
            end
            SEC_3:
            begin
                red_next = 8'd0;   green_next = xval;   blue_next = 8'd255;
            end
            SEC_4:
            begin
                red_next = xval;   green_next = 8'd0;   blue_next = 8'd255;
            end
            default:
            begin
                red_next = 8'd255; green_next = 8'd0;   blue_next = xval;
            end
        endcase
        if (!mode5_reg)
        begin
            red_next   = rgb5_reg[23:16];
            green_next = rgb5_reg[15:8];
            blue_next  = rgb5_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= div_valid;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg  <= div_side.mode;
        rgb1_reg   <= {div_side.red, div_side.green, div_side.blue};
        aprod1_reg <= aprod1_next;
        sprod1_reg <= sprod1_next;
        hraw1_reg  <= hraw1_next;
        cx1_reg    <= div_side.cx;
        cy1_reg    <= div_side.cy;

        mode2_reg  <= mode1_reg;
        rgb2_reg   <= rgb1_reg;
        alpha2_reg <= aprod1_reg[23:16];
        rv2_reg    <= sprod1_reg[31:20];
        hue2_reg   <= 28'(hwrap);
        cx2_reg    <= cx1_reg;
        cy2_reg    <= cy1_reg;

        mode3_reg  <= mode2_reg;
        rgb3_reg   <= rgb2_reg;
        alpha3_reg <= alpha2_reg;
        rprod3_reg <= 25'(rv2_reg) * 25'(RECIP_10);
        sec3_reg   <= sec_next;
        frac3_reg  <= frac_full[25:0];
        cx3_reg    <= cx2_reg;
        cy3_reg    <= cy2_reg;

        mode4_reg  <= mode3_reg;
        rgb4_reg   <= rgb3_reg;
        alpha4_reg <= alpha3_reg;
        rad4_reg   <= rprod3_reg[23:16];
        sec4_reg   <= sec3_reg;
        xnum4_reg  <= g255[33:19];
        cx4_reg    <= cx3_reg;
        cy4_reg    <= cy3_reg;

        mode5_reg  <= mode4_reg;
        rgb5_reg   <= rgb4_reg;
        alpha5_reg <= alpha4_reg;
        rad5_reg   <= rad4_reg;
        sec5_reg   <= sec4_reg;
        xprod5_reg <= 30'(xnum4_reg) * 30'(RECIP_75);
        cx5_reg    <= cx4_reg;
        cy5_reg    <= cy4_reg;

        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
        alpha_reg  <= alpha5_reg;
        rad_reg    <= rad5_reg;
        cx_reg     <= cx5_reg;
        cy_reg     <= cy5_reg;
    end

    assign done       = done_reg;
    assign out_red    = red_reg;
    assign out_green  = green_reg;
    assign out_blue   = blue_reg;
    assign out_alpha  = alpha_reg;
    assign center_x   = cx_reg;
    assign center_y   = cy_reg;
    assign dot_radius = rad_reg;

endmodule

// ===== rtl/pfcs_div.sv =====
// pipelined restoring divider for the life ratio, one quotient bit per stage
// depends on pfcs_pkg
module pfcs_div
    import pfcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [15:0] in_left,
    input  logic [15:0] in_total,
    input  side_t       in_side,
    output logic        out_valid,
    output logic [15:0] out_quot,
    output side_t       out_side
);

    logic        vld_reg  [0:DIV_STEPS];
    logic [16:0] rem_reg  [0:DIV_STEPS];
    logic [15:0] quot_reg [0:DIV_STEPS];
    logic [15:0] den_reg  [0:DIV_STEPS];
    side_t       side_reg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= {1'b0, in_left};
        quot_reg[0] <= '0;
        den_reg[0]  <= in_total;
        side_reg[0] <= in_side;
    end

    genvar i;
    generate
        for (i = 1; i <= DIV_STEPS; i++)
        begin : g_step
            logic [16:0] shift_val;
            logic        take;
            logic [16:0] rem_next;
            logic [15:0] quot_next;

            always_comb
            begin
                shift_val = {rem_reg[i-1][15:0], 1'b0};
                take      = shift_val >= {1'b0, den_reg[i-1]};
                rem_next  = take ? shift_val - {1'b0, den_reg[i-1]} : shift_val;
                quot_next = {quot_reg[i-1][14:0], take};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[i]  <= rem_next;
                quot_reg[i] <= quot_next;
                den_reg[i]  <= den_reg[i-1];
                side_reg[i] <= side_reg[i-1];
            end
        end
    endgenerate

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_quot  = quot_reg[DIV_STEPS];
    assign out_side  = side_reg[DIV_STEPS];

endmodule

// ===== rtl/pfcs_chk.sv =====
// port-level checker for particle_fade_color_size, bound to the top level
// depends on pfcs_pkg
module pfcs_chk
    import pfcs_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic is_live,
    input logic done
);

    // a word can always enter
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // a live word that enters yields a result word marked by done
    a_live_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_live) |-> ##LATENCY done)
        else $error("missing result word");

    // no result word without a live word in front of it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy && is_live) |-> ##LATENCY !done)
        else $error("unexpected result word");

endmodule

bind particle_fade_color_size pfcs_chk u_pfcs_chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .is_live (is_live),
    .done    (done)
);

// ===== verif/particle_fade_color_size_tb.sv =====
// testbench for particle_fade_color_size: random and directed particle words
// against an integer predictor of fade, radius, center and hue color
// depends on pfcs_pkg and the particle_fade_color_size rtl
`timescale 1ns / 100ps

module particle_fade_color_size_tb;
    import pfcs_pkg::*;

    typedef struct {
        logic               live;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [15:0]        left;
        logic [15:0]        total;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic [11:0]        size;
    } particle_t;

    typedef struct {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic signed [11:0] cx;
        logic signed [11:0] cy;
        logic [7:0]         radius;
    } draw_t;

    localparam int WATCHDOG_LIMIT = 2000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_we = 1'b0;
    logic cfg_data = 1'b0;
    logic is_live = 1'b0;
    logic signed [15:0] pos_x = '0;
    logic signed [15:0] pos_y = '0;
    logic [15:0] life_left = '0;
    logic [15:0] life_total = '0;
    logic [7:0] base_red = '0;
    logic [7:0] base_green = '0;
    logic [7:0] base_blue = '0;
    logic [7:0] base_alpha = '0;
    logic [11:0] dot_size = '0;
    logic done;
    logic [7:0] out_red, out_green, out_blue, out_alpha, dot_radius;
    logic signed [11:0] center_x, center_y;

    particle_t pending_words[$];
    draw_t expected_draws[$];
    logic rainbow = 1'b0;
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit feeding = 1'b0;

    particle_fade_color_size dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .is_live(is_live), .pos_x(pos_x), .pos_y(pos_y),
        .life_left(life_left), .life_total(life_total),
        .base_red(base_red), .base_green(base_green), .base_blue(base_blue),
        .base_alpha(base_alpha), .dot_size(dot_size),
        .done(done), .out_red(out_red), .out_green(out_green),
        .out_blue(out_blue), .out_alpha(out_alpha),
        .center_x(center_x), .center_y(center_y), .dot_radius(dot_radius)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic draw_t predict_draw(particle_t p, logic mode);
        draw_t d;
        longint ratio, hue, sector, frac, x;
        ratio = (p.total == 0 || p.left >= p.total) ? 65536
              : ((longint'(p.left) << 16) / p.total);
        d.red = p.red;
        d.green = p.green;
        d.blue = p.blue;
        if (mode)
        begin
            hue = ratio * 3600 + (longint'(p.px) + longint'(p.py)) * 4096;
            hue = hue % 235929600;
            if (hue < 0)
                hue += 235929600;
            sector = hue / 39321600;
            frac = hue % 39321600;
            x = (sector % 2 == 0) ? (255 * frac / 39321600)
              : (255 * (39321600 - frac) / 39321600);
            case (sector)
                0: begin d.red = 255; d.green = x[7:0]; d.blue = 0; end
                1: begin d.red = x[7:0]; d.green = 255; d.blue = 0; end
                2: begin d.red = 0; d.green = 255; d.blue = x[7:0]; end
                3: begin d.red = 0; d.green = x[7:0]; d.blue = 255; end
                4: begin d.red = x[7:0]; d.green = 0; d.blue = 255; end
                default: begin d.red = 255; d.green = 0; d.blue = x[7:0]; end
            endcase
        end
        d.alpha = 8'((longint'(p.alpha) * ratio) >> 16);
        d.cx = 12'(int'(p.px) / 16);
        d.cy = 12'(int'(p.py) / 16);
        d.radius = 8'((longint'(p.size) * (7 * 65536 + 3 * ratio)) / (10 * 1048576));
        return d;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // driver
    always @(negedge clk)
    begin
        particle_t p;
        if (feeding && pending_words.size() > 0 && !(start && busy)
            && (calm || $urandom_range(99) >= 32))
        begin
            p = pending_words.pop_front();
            start <= 1'b1;
            is_live <= p.live;
            pos_x <= p.px;
            pos_y <= p.py;
            life_left <= p.left;
            life_total <= p.total;
            base_red <= p.red;
            base_green <= p.green;
            base_blue <= p.blue;
            base_alpha <= p.alpha;
            dot_size <= p.size;
            if (p.live)
                expected_draws.push_back(predict_draw(p, rainbow));
        end
        else if (start && !busy)
        begin
            start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        draw_t e;
        if (rst_n && ((start && !busy) || done))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (rst_n && done)
        begin
            if (expected_draws.size() == 0)
            begin
                report_mismatch("unexpected result word", 1, 0);
            end
            else
            begin
                e = expected_draws.pop_front();
                if (out_red !== e.red) report_mismatch("red", out_red, e.red);
                if (out_green !== e.green) report_mismatch("green", out_green, e.green);
                if (out_blue !== e.blue) report_mismatch("blue", out_blue, e.blue);
                if (out_alpha !== e.alpha) report_mismatch("alpha", out_alpha, e.alpha);
                if (center_x !== e.cx) report_mismatch("center_x", center_x, e.cx);
                if (center_y !== e.cy) report_mismatch("center_y", center_y, e.cy);
                if (dot_radius !== e.radius)
                    report_mismatch("radius", dot_radius, e.radius);
            end
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic particle_t random_particle();
        particle_t p;
        p.live = ($urandom_range(9) != 0);
        p.px = 16'($urandom);
        p.py = 16'($urandom);
        p.total = 16'($urandom);
        case ($urandom_range(9))
            0: p.left = p.total;
            1: p.left = 16'($urandom);
            2:
            begin
                p.total = 0;
                p.left = 16'($urandom);
            end
            default: p.left = (p.total == 0) ? 16'd0 : 16'($urandom_range(p.total - 1));
        endcase
        if ($urandom_range(9) == 0)
            p.left = 16'($urandom);
        p.red = 8'($urandom);
        p.green = 8'($urandom);
        p.blue = 8'($urandom);
        p.alpha = 8'($urandom);
        p.size = 12'($urandom);
        return p;
    endfunction

    function automatic particle_t make_particle(logic live, int px, int py,
        int left, int total, int col, int size);
        particle_t p;
        p.live = live;
        p.px = 16'(px);
        p.py = 16'(py);
        p.left = 16'(left);
        p.total = 16'(total);
        p.red = 8'(col);
        p.green = 8'(col ^ 8'h5a);
        p.blue = 8'(~col);
        p.alpha = 8'(col);
        p.size = 12'(size);
        return p;
    endfunction

    task automatic run_phase(int count, bit directed);
        if (directed)
        begin
            pending_words.push_back(make_particle(1, 0, 0, 0, 0, 255, 4095));
            pending_words.push_back(make_particle(1, 32767, 32767, 65535, 65535, 0, 0));
            pending_words.push_back(make_particle(1, -32768, -32768, 0, 65535, 255, 4095));
            pending_words.push_back(make_particle(1, -17, 17, 65535, 1, 128, 100));
            pending_words.push_back(make_particle(1, -1, -1, 1, 65535, 170, 2048));
            pending_words.push_back(make_particle(0, 123, 456, 7, 9, 85, 77));
            pending_words.push_back(make_particle(1, -2000, -3000, 100, 200, 1, 4095));
            pending_words.push_back(make_particle(1, 15, -15, 32768, 65535, 200, 1));
            pending_words.push_back(make_particle(1, 600, 0, 0, 1, 99, 4095));
            pending_words.push_back(make_particle(1, 1200, 1200, 3, 5, 33, 3000));
        end
        for (int i = 0; i < count; i++)
            pending_words.push_back(random_particle());
        feeding = 1'b1;
        wait (pending_words.size() == 0 && !start);
        wait (expected_draws.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        feeding = 1'b0;
    endtask

    task automatic write_mode(logic value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        rainbow = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_phase(300, 1'b1);
        write_mode(1'b1);
        run_phase(400, 1'b1);
        calm = 1'b1;
        run_phase(200, 1'b0);
        calm = 1'b0;
        write_mode(1'b0);
        run_phase(200, 1'b0);
        write_mode(1'b1);
        run_phase(250, 1'b0);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/pfcs_pkg.sv
rtl/pfcs_div.sv
rtl/particle_fade_color_size.sv
rtl/pfcs_chk.sv
verif/particle_fade_color_size_tb.sv
